### rtl/dmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants for the depth-first maze carver
// Request/response payloads, register indexes, direction and wall codes.
// ----------------------------------------------------------------------------
package dmc_pkg;

   localparam int CFG_W           = 7;
   localparam int RND_W           = 16;
   localparam int COORD_W         = 6;
   localparam int CNT_W           = 3;
   localparam int IDX_W           = 2;
   localparam int DIGITS_PER_STEP = 4;
   localparam int REM_STEPS       = RND_W / DIGITS_PER_STEP;
   localparam int REM_CNT_W       = $clog2(REM_STEPS);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_CARVE = 1'b1;

   localparam logic WALL_LEFT   = 1'b0;
   localparam logic WALL_BOTTOM = 1'b1;

   localparam logic CSR_MAZE_ROWS = 1'b0;
   localparam logic CSR_MAZE_COLS = 1'b1;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef struct packed {
      logic             req_type;
      logic [RND_W-1:0] random_word;
   } dmc_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] wall_row;
      logic [COORD_W-1:0] wall_col;
      logic               wall_kind;
      logic               wall_valid;
      logic               maze_done;
   } dmc_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dmc_rem_status_type;

endpackage
`default_nettype wire

### rtl/dmc_rem_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmc_rem_unit: iterative remainder of the random word by a small count
// Restoring shift-subtract, DIGITS_PER_STEP dividend bits per cycle.
// ----------------------------------------------------------------------------
module dmc_rem_unit
   import dmc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [RND_W-1:0]         dividend,
   input  logic [CNT_W-1:0]         divisor,
   output dmc_rem_status_type       status,
   output logic [IDX_W-1:0]         remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     div_ff, div_in;

   always_comb begin
      logic [CNT_W-1:0] acc;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      acc      = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         for (int i = 0; i < DIGITS_PER_STEP; i++) begin
            acc = {acc[IDX_W-1:0], shift_ff[RND_W-1-i]};
            if (acc >= div_ff) begin
               acc = acc - div_ff;
            end
         end
         rem_in   = acc;
         shift_in = shift_ff << DIGITS_PER_STEP;
         cnt_in   = cnt_ff + REM_CNT_W'(1);
         if (cnt_ff == REM_CNT_W'(REM_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff[IDX_W-1:0];

endmodule
`default_nettype wire

### rtl/dfs_maze_carver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_maze_carver: randomized depth-first maze carving engine
// Requests on req_* (valid/ready), one response per request on rsp_* (valid/
// ready), size registers on csr_* (write only, index 0 rows, 1 columns).
// A start request sweeps the visited map one cell per cycle and answers once
// the sweep ends. A carve request examines stack tops: each takes a stack
// read, load, four visited map reads, drain and count on the single visited
// map read port; a top with no open neighbor is popped. The pick then runs
// in the remainder unit, followed by carve and output. A carve on an idle
// carver answers done without reading the stack; a carve that pops the last
// top answers done. One request is in flight at a time; req_ready is high
// only when the engine is idle and no result waits for the output register.
// The response sits in an output register; if the receiver stalls, the
// engine holds the next result until that register frees. Reset clears
// control state and sets both sizes to 8; the visited map is swept by the
// start request, not by reset.
// ----------------------------------------------------------------------------
module dfs_maze_carver
   import dmc_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dmc_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmc_rsp_type       rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int LW         = $clog2(CELL_COUNT + 1);
   localparam int RW         = $clog2(MAX_ROWS);
   localparam int CW         = $clog2(MAX_COLS);
   localparam int RSW        = $clog2(MAX_ROWS + 1);
   localparam int CSW        = $clog2(MAX_COLS + 1);
   localparam int RCMPW      = (RSW > CFG_W) ? RSW : CFG_W;
   localparam int CCMPW      = (CSW > CFG_W) ? CSW : CFG_W;

   typedef struct packed {
      logic [RW-1:0] row;
      logic [CW-1:0] col;
   } cell_type;

   typedef struct packed {
      logic     inb;
      cell_type pos;
   } nbr_type;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_FETCH = 9'b000000100,
      S_LOAD  = 9'b000001000,
      S_PROBE = 9'b000010000,
      S_DRAIN = 9'b000100000,
      S_COUNT = 9'b001000000,
      S_MOD   = 9'b010000000,
      S_CARVE = 9'b100000000
   } state_type;

   // result waiting for the output register
   logic              out_ff, out_in;

   function automatic nbr_type nbr(input logic [1:0] d, input cell_type p,
                                   input logic [RSW-1:0] rows,
                                   input logic [CSW-1:0] cols);
      nbr_type n;
      logic    rin;
      logic    cin;
      rin    = RSW'(p.row) < rows;
      cin    = CSW'(p.col) < cols;
      n.pos  = p;
      n.inb  = 1'b0;
      unique case (d)
         DIR_DOWN: begin
            n.pos.row = p.row + RW'(1);
            n.inb     = (RSW'(p.row) + RSW'(1) < rows) && cin;
         end
         DIR_RIGHT: begin
            n.pos.col = p.col + CW'(1);
            n.inb     = rin && (CSW'(p.col) + CSW'(1) < cols);
         end
         DIR_UP: begin
            n.pos.row = p.row - RW'(1);
            n.inb     = (p.row != '0) && (RSW'(p.row) - RSW'(1) < rows) && cin;
         end
         DIR_LEFT: begin
            n.pos.col = p.col - CW'(1);
            n.inb     = rin && (p.col != '0) && (CSW'(p.col) - CSW'(1) < cols);
         end
         default: n.inb = 1'b0;
      endcase
      return n;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input cell_type p);
      return AW'(p.row) * AW'(MAX_COLS) + AW'(p.col);
   endfunction

   function automatic logic [1:0] pick_dir(input logic [3:0] open,
                                           input logic [IDX_W-1:0] idx);
      logic [CNT_W-1:0] k;
      logic [1:0]       d;
      k = '0;
      d = DIR_DOWN;
      for (int i = 0; i < 4; i++) begin
         if (open[i]) begin
            if (k == CNT_W'(idx)) begin
               d = 2'(i);
            end
            k = k + CNT_W'(1);
         end
      end
      return d;
   endfunction

   state_type          state_ff, state_in;
   logic [LW-1:0]      level_ff, level_in;
   logic               active_ff, active_in;
   logic [CFG_W-1:0]   rows_ff, rows_in;
   logic [CFG_W-1:0]   cols_ff, cols_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff, pend_in;

   dmc_rsp_type        rsp_data_ff, rsp_data_in;
   dmc_rsp_type        res_ff, res_in;
   logic [RND_W-1:0]   rnd_ff, rnd_in;
   cell_type           cur_ff, cur_in;
   logic [1:0]         dir_ff, dir_in;
   logic [3:0]         open_ff, open_in;
   logic [1:0]         pend_dir_ff, pend_dir_in;
   logic               pend_inb_ff, pend_inb_in;
   logic [AW-1:0]      clr_ff, clr_in;

   logic               vis_mem [CELL_COUNT];
   logic               vis_rd_ff;
   logic               vis_we;
   logic [AW-1:0]      vis_waddr;
   logic               vis_wdata;
   logic [AW-1:0]      vis_raddr;

   cell_type           stk_mem [CELL_COUNT];
   cell_type           stk_rd_ff;
   logic               stk_we;
   logic [AW-1:0]      stk_waddr;
   cell_type           stk_wdata;
   logic [AW-1:0]      stk_raddr;

   logic [RSW-1:0]     rows_eff;
   logic [CSW-1:0]     cols_eff;
   logic [LW-1:0]      lvl_m1;
   logic [CNT_W-1:0]   open_cnt;
   nbr_type            probe;
   nbr_type            carve;
   logic [1:0]         sel_dir;

   logic               rem_start;
   dmc_rem_status_type rem_status;
   logic [IDX_W-1:0]   rem_idx;

   dmc_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rnd_ff),
      .divisor   (open_cnt),
      .status    (rem_status),
      .remainder (rem_idx)
   );

   always_comb begin
      priority if (rows_ff == '0) begin
         rows_eff = RSW'(1);
      end else if (RCMPW'(rows_ff) > RCMPW'(MAX_ROWS)) begin
         rows_eff = RSW'(MAX_ROWS);
      end else begin
         rows_eff = RSW'(rows_ff);
      end
      priority if (cols_ff == '0) begin
         cols_eff = CSW'(1);
      end else if (CCMPW'(cols_ff) > CCMPW'(MAX_COLS)) begin
         cols_eff = CSW'(MAX_COLS);
      end else begin
         cols_eff = CSW'(cols_ff);
      end
   end

   always_comb begin
      open_cnt = '0;
      for (int i = 0; i < 4; i++) begin
         open_cnt = open_cnt + CNT_W'(open_ff[i]);
      end
   end

   assign lvl_m1  = level_ff - LW'(1);
   assign probe   = nbr(dir_ff, cur_ff, rows_eff, cols_eff);
   assign sel_dir = pick_dir(open_ff, rem_idx);
   assign carve   = nbr(sel_dir, cur_ff, rows_eff, cols_eff);

   always_comb begin
      state_in     = state_ff;
      out_in       = out_ff;
      level_in     = level_ff;
      active_in    = active_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      rnd_in       = rnd_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      open_in      = open_ff;
      clr_in       = clr_ff;
      pend_in      = 1'b0;
      pend_dir_in  = dir_ff;
      pend_inb_in  = 1'b0;
      vis_we       = 1'b0;
      vis_waddr    = '0;
      vis_wdata    = 1'b0;
      vis_raddr    = '0;
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = '0;
      stk_raddr    = '0;
      rem_start    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAZE_ROWS: rows_in = csr_wdata;
            CSR_MAZE_COLS: cols_in = csr_wdata;
            default:       rows_in = rows_ff;
         endcase
      end

      if (pend_ff) begin
         open_in[pend_dir_ff] = pend_inb_ff & ~vis_rd_ff;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (out_ff) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_ff;
            out_in       = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  rnd_in = req_data.random_word;
                  res_in = '0;
                  priority if (req_data.req_type == REQ_START) begin
                     clr_in   = AW'(CELL_COUNT - 1);
                     state_in = S_CLEAR;
                  end else if (req_data.req_type == REQ_CARVE && !active_ff) begin
                     res_in.maze_done = 1'b1;
                     out_in           = 1'b1;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            end
            S_CLEAR: begin
               vis_we    = 1'b1;
               vis_waddr = clr_ff;
               vis_wdata = (clr_ff == '0);
               if (clr_ff == '0) begin
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = '0;
                  level_in  = LW'(1);
                  active_in = 1'b1;
                  state_in  = S_IDLE;
                  out_in    = 1'b1;
               end else begin
                  clr_in = clr_ff - AW'(1);
               end
            end
            S_FETCH: begin
               if (level_ff == '0) begin
                  active_in        = 1'b0;
                  res_in.maze_done = 1'b1;
                  state_in         = S_IDLE;
                  out_in           = 1'b1;
               end else begin
                  stk_raddr = lvl_m1[AW-1:0];
                  state_in  = S_LOAD;
               end
            end
            S_LOAD: begin
               cur_in   = stk_rd_ff;
               dir_in   = DIR_DOWN;
               open_in  = '0;
               state_in = S_PROBE;
            end
            S_PROBE: begin
               vis_raddr   = probe.inb ? cell_addr(probe.pos) : '0;
               pend_in     = 1'b1;
               pend_dir_in = dir_ff;
               pend_inb_in = probe.inb;
               dir_in      = dir_ff + 2'd1;
               if (dir_ff == DIR_LEFT) begin
                  state_in = S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_in = S_COUNT;
            end
            S_COUNT: begin
               if (open_cnt == '0) begin
                  level_in = lvl_m1;
                  state_in = S_FETCH;
               end else begin
                  rem_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
            S_MOD: begin
               if (rem_status.done) begin
                  state_in = S_CARVE;
               end
            end
            S_CARVE: begin
               vis_we    = 1'b1;
               vis_waddr = cell_addr(carve.pos);
               vis_wdata = 1'b1;
               if (level_ff < LW'(CELL_COUNT)) begin
                  stk_we    = 1'b1;
                  stk_waddr = level_ff[AW-1:0];
                  stk_wdata = carve.pos;
                  level_in  = level_ff + LW'(1);
               end
               res_in.wall_valid = 1'b1;
               unique case (sel_dir)
                  DIR_DOWN: begin
                     res_in.wall_row  = COORD_W'(cur_ff.row);
                     res_in.wall_col  = COORD_W'(cur_ff.col);
                     res_in.wall_kind = WALL_BOTTOM;
                  end
                  DIR_RIGHT: begin
                     res_in.wall_row  = COORD_W'(carve.pos.row);
                     res_in.wall_col  = COORD_W'(carve.pos.col);
                     res_in.wall_kind = WALL_LEFT;
                  end
                  DIR_UP: begin
                     res_in.wall_row  = COORD_W'(carve.pos.row);
                     res_in.wall_col  = COORD_W'(carve.pos.col);
                     res_in.wall_kind = WALL_BOTTOM;
                  end
                  default: begin
                     res_in.wall_row  = COORD_W'(cur_ff.row);
                     res_in.wall_col  = COORD_W'(cur_ff.col);
                     res_in.wall_kind = WALL_LEFT;
                  end
               endcase
               state_in = S_IDLE;
               out_in   = 1'b1;
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_ff       <= 1'b0;
         level_ff     <= '0;
         active_ff    <= 1'b0;
         rows_ff      <= CFG_W'(8);
         cols_ff      <= CFG_W'(8);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_ff       <= out_in;
         level_ff     <= level_in;
         active_ff    <= active_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      rnd_ff      <= rnd_in;
      cur_ff      <= cur_in;
      dir_ff      <= dir_in;
      open_ff     <= open_in;
      pend_dir_ff <= pend_dir_in;
      pend_inb_ff <= pend_inb_in;
      clr_ff      <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_waddr] <= vis_wdata;
      end
      vis_rd_ff <= vis_mem[vis_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(CELL_COUNT))
      else $error("stack level beyond capacity");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> level_ff == '0)
      else $error("stack not empty while carver idle");

   a_carve_inb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CARVE && !out_ff) |-> carve.inb)
      else $error("carved neighbor out of bounds");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> CNT_W'(rem_idx) < open_cnt)
      else $error("neighbor index not below count");

   a_rem_busy: assert property (@(posedge clock) disable iff (reset)
      rem_status.busy |-> state_ff == S_MOD)
      else $error("remainder unit busy outside pick");

   a_wall_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.wall_valid) |-> !rsp_data_ff.maze_done)
      else $error("response both carved and done");

endmodule
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for dfs_maze_carver
// Drives start and carve requests with bursty gaps and a stalling response
// side. Every accepted request runs through a local maze predictor (visited
// map, path stack, size registers), and each response is compared field by
// field against the oldest pending prediction. Directed cases cover idle
// carves, a one-cell grid, size clamping, restarts and mid-maze resizing.
// Random mazes of mixed shapes follow.
// ----------------------------------------------------------------------------
module testbench;
   import dmc_pkg::*;

   localparam int GRID_ROWS    = 64;
   localparam int GRID_COLS    = 64;
   localparam int GRID_CELLS   = GRID_ROWS * GRID_COLS;
   localparam int REQ_TARGET   = 1550;
   localparam int MAZE_CAP     = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 20000;

   typedef enum int {RX_OPEN, RX_COIN, RX_THIRDS, RX_SPARSE} rx_mode_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   dmc_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   dmc_rsp_type       rsp_data;
   logic              csr_wr_en;
   logic              csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   // predictor state
   bit [GRID_CELLS-1:0] seen_cell;
   logic [11:0]         trail [GRID_CELLS];
   int                  trail_depth;
   bit                  carving;
   logic [CFG_W-1:0]    rows_cfg;
   logic [CFG_W-1:0]    cols_cfg;

   dmc_rsp_type         pending_walls [$];
   dmc_rsp_type         want;
   int                  errors;
   int                  requests_sent;
   int                  burst_left;
   bit                  hold_rsp;
   rx_mode_type         rx_mode;
   int                  rx_timer;
   int                  rx_count;

   dfs_maze_carver #(
      .MAX_ROWS (GRID_ROWS),
      .MAX_COLS (GRID_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void step_cell(input int r, input int c, input logic [1:0] dir,
                                     output int nr, output int nc);
      nr = r;
      nc = c;
      case (dir)
         DIR_DOWN:  nr = r + 1;
         DIR_RIGHT: nc = c + 1;
         DIR_UP:    nr = r - 1;
         default:   nc = c - 1;
      endcase
   endfunction

   function automatic dmc_rsp_type next_wall(dmc_req_type rq);
      dmc_rsp_type res;
      int          rows;
      int          cols;
      int          cur_r;
      int          cur_c;
      int          nr;
      int          nc;
      int          n_open;
      logic [1:0]  open_dirs [4];
      logic [1:0]  pick;
      res = '0;
      cur_r = 0;
      cur_c = 0;
      rows = (rows_cfg == 0) ? 1 : ((rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg));
      cols = (cols_cfg == 0) ? 1 : ((cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg));
      if (rq.req_type == REQ_START) begin
         seen_cell    = '0;
         seen_cell[0] = 1'b1;
         trail[0]     = '0;
         trail_depth  = 1;
         carving      = 1'b1;
      end else if (!carving) begin
         res.maze_done = 1'b1;
      end else begin
         n_open = 0;
         // drop dead ends until a top with an unvisited neighbor remains
         while (trail_depth > 0 && n_open == 0) begin
            cur_r = trail[trail_depth-1] / GRID_COLS;
            cur_c = trail[trail_depth-1] % GRID_COLS;
            for (int d = 0; d < 4; d++) begin
               step_cell(cur_r, cur_c, d[1:0], nr, nc);
               if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
                   !seen_cell[nr*GRID_COLS+nc]) begin
                  open_dirs[n_open] = d[1:0];
                  n_open++;
               end
            end
            if (n_open == 0) trail_depth--;
         end
         if (trail_depth == 0) begin
            carving       = 1'b0;
            res.maze_done = 1'b1;
         end else begin
            pick = open_dirs[rq.random_word % n_open];
            step_cell(cur_r, cur_c, pick, nr, nc);
            case (pick)
               DIR_DOWN: begin
                  res.wall_row  = COORD_W'(cur_r);
                  res.wall_col  = COORD_W'(cur_c);
                  res.wall_kind = WALL_BOTTOM;
               end
               DIR_RIGHT: begin
                  res.wall_row  = COORD_W'(nr);
                  res.wall_col  = COORD_W'(nc);
                  res.wall_kind = WALL_LEFT;
               end
               DIR_UP: begin
                  res.wall_row  = COORD_W'(nr);
                  res.wall_col  = COORD_W'(nc);
                  res.wall_kind = WALL_BOTTOM;
               end
               default: begin
                  res.wall_row  = COORD_W'(cur_r);
                  res.wall_col  = COORD_W'(cur_c);
                  res.wall_kind = WALL_LEFT;
               end
            endcase
            res.wall_valid = 1'b1;
            seen_cell[nr*GRID_COLS+nc] = 1'b1;
            if (trail_depth < GRID_CELLS) begin
               trail[trail_depth] = 12'(nr * GRID_COLS + nc);
               trail_depth++;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [CFG_W-1:0] pick_extent();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return CFG_W'($urandom_range(1, 8));
      else if (roll < 85) return CFG_W'($urandom_range(9, 64));
      else if (roll < 90) return CFG_W'(GRID_ROWS);
      else if (roll < 95) return '0;
      else return CFG_W'($urandom_range(65, 127));
   endfunction

   // one request; valid stays up inside a burst, drops for a random gap after it
   task automatic send_request(input logic kind, input logic [RND_W-1:0] word);
      dmc_req_type rq;
      rq.req_type    = kind;
      rq.random_word = word;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      pending_walls = {pending_walls, next_wall(rq)};
      requests_sent++;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_walls.size() != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MAZE_ROWS) rows_cfg = val;
      else cols_cfg = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      drain_responses();
      write_size(CSR_MAZE_ROWS, rows);
      write_size(CSR_MAZE_COLS, cols);
   endtask

   task automatic report_field(input string field, input int unsigned exp_val,
                               input int unsigned act_val);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_walls.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, rsp_data);
            errors++;
         end else begin
            want = pending_walls.pop_front();
            if (rsp_data.wall_row !== want.wall_row)
               report_field("wall_row", want.wall_row, rsp_data.wall_row);
            if (rsp_data.wall_col !== want.wall_col)
               report_field("wall_col", want.wall_col, rsp_data.wall_col);
            if (rsp_data.wall_kind !== want.wall_kind)
               report_field("wall_kind", want.wall_kind, rsp_data.wall_kind);
            if (rsp_data.wall_valid !== want.wall_valid)
               report_field("wall_valid", want.wall_valid, rsp_data.wall_valid);
            if (rsp_data.maze_done !== want.maze_done)
               report_field("maze_done", want.maze_done, rsp_data.maze_done);
         end
      end
   end

   // response side stall patterns
   initial begin
      rsp_ready = 1'b0;
      rx_mode   = RX_OPEN;
      rx_timer  = 0;
      rx_count  = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            if (rx_timer == 0) begin
               rx_mode  = rx_mode_type'($urandom_range(0, 3));
               rx_timer = $urandom_range(20, 120);
            end else begin
               rx_timer--;
            end
            rx_count++;
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_THIRDS: rsp_ready <= (rx_count % 3) != 0;
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog on handshake silence
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   task automatic test_carve_while_idle();
      send_request(REQ_CARVE, '0);
      send_request(REQ_CARVE, '1);
      drain_responses();
   endtask

   task automatic test_single_cell();
      set_grid(7'd1, 7'd1);
      send_request(REQ_START, '0);
      send_request(REQ_CARVE, '1);
      send_request(REQ_CARVE, '0);
      drain_responses();
   endtask

   task automatic test_size_clamping();
      set_grid('0, '0);
      send_request(REQ_START, '1);
      send_request(REQ_CARVE, 16'h5a5a);
      set_grid('1, '1);
      send_request(REQ_START, 16'ha5a5);
      send_request(REQ_CARVE, '0);
      send_request(REQ_CARVE, '1);
      send_request(REQ_CARVE, 16'd1);
      send_request(REQ_CARVE, RND_W'($urandom));
      // exact maximum while still carving
      set_grid(7'd64, 7'd64);
      send_request(REQ_CARVE, 16'd2);
      send_request(REQ_CARVE, 16'd3);
      drain_responses();
   endtask

   task automatic test_restart_and_resize();
      set_grid(7'd3, 7'd5);
      send_request(REQ_START, RND_W'($urandom));
      repeat (4) send_request(REQ_CARVE, RND_W'($urandom));
      send_request(REQ_START, RND_W'($urandom));
      repeat (2) send_request(REQ_CARVE, RND_W'($urandom));
      // shrink under a live stack
      set_grid(7'd2, 7'd2);
      while (carving) send_request(REQ_CARVE, RND_W'($urandom));
      send_request(REQ_CARVE, RND_W'($urandom));
      drain_responses();
   endtask

   task automatic test_output_backpressure();
      set_grid(7'd8, 7'd8);
      send_request(REQ_START, RND_W'($urandom));
      drain_responses();
      hold_rsp = 1'b1;
      burst_left = 30;
      repeat (20) send_request(REQ_CARVE, RND_W'($urandom));
      drain_responses();
   endtask

   task automatic test_random_mazes();
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      int               extra;
      int               carves;
      int               roll;
      while (requests_sent < REQ_TARGET) begin
         rows = pick_extent();
         cols = pick_extent();
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
               rows = CFG_W'($urandom_range(1, 2));
               cols = CFG_W'($urandom_range(32, 64));
            end else begin
               rows = CFG_W'($urandom_range(32, 64));
               cols = CFG_W'($urandom_range(1, 2));
            end
         end
         set_grid(rows, cols);
         send_request(REQ_START, RND_W'($urandom));
         extra  = $urandom_range(0, 2);
         carves = 0;
         while (carves < MAZE_CAP && (carving || extra > 0) &&
                requests_sent < REQ_TARGET) begin
            if (!carving) extra--;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               send_request(REQ_START, RND_W'($urandom));
            end else if (roll < 4) begin
               set_grid(pick_extent(), pick_extent());
            end else begin
               send_request(REQ_CARVE, RND_W'($urandom));
               carves++;
            end
         end
      end
      drain_responses();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_MAZE_ROWS;
      csr_wdata     = '0;
      seen_cell     = '0;
      trail_depth   = 0;
      carving       = 1'b0;
      rows_cfg      = 7'd8;
      cols_cfg      = 7'd8;
      errors        = 0;
      requests_sent = 0;
      burst_left    = 0;
      hold_rsp      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_carve_while_idle();
      test_single_cell();
      test_size_clamping();
      test_restart_and_resize();
      test_output_backpressure();
      test_random_mazes();

      drain_responses();
      repeat (16) @(posedge clock);
      if (pending_walls.size() != 0) errors++;
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
